@@ rtl/key_repeat_dispatcher_top_assert.svh @@
// Assertion macros used by the key repeat dispatcher checker.
`ifndef KEY_REPEAT_DISPATCHER_TOP_ASSERT_SVH
`define KEY_REPEAT_DISPATCHER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("krd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("krd assertion failed");

`endif

@@ rtl/krd_pkg.sv @@
// Types and constants of the key repeat dispatcher.
package krd_pkg;

  localparam int unsigned KeyW      = 4;
  localparam int unsigned CntW      = 16;
  localparam int unsigned RepMaskW  = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CntW-1:0]     DelayRst  = 16'd500;
  localparam logic [CntW-1:0]     PeriodRst = 16'd30;
  localparam logic [RepMaskW-1:0] MaskRst   = 9'd60;

  localparam logic ActKey  = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY  = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_MASK   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;   // input transaction completes this cycle
    logic pop;    // move next pending repeat into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register empty or being drained
    logic rep_start;  // current input starts a repeat burst
    logic pend_one;   // one repeat left to send
  } dp_status_t;

endpackage

@@ rtl/krd_if.sv @@
// Handshake channel interfaces: input items, result items, configuration writes.
interface krd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [krd_pkg::KeyW-1:0] key_code;
  logic                     pressed;
  modport source (output valid, action, key_code, pressed, input ready);
  modport sink   (input valid, action, key_code, pressed, output ready);
endinterface

interface krd_out_if;
  logic                     valid;
  logic                     ready;
  logic [krd_pkg::KeyW-1:0] out_key;
  logic                     out_pressed;
  logic                     is_repeat;
  logic                     last;
  modport source (output valid, out_key, out_pressed, is_repeat, last, input ready);
  modport sink   (input valid, out_key, out_pressed, is_repeat, last, output ready);
endinterface

interface krd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [krd_pkg::CfgIdxW-1:0]  index;
  logic [krd_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/krd_ctrl.sv @@
// Controller: accepts input transactions and sequences repeat bursts.
module krd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  krd_pkg::dp_status_t status_i,
  output krd_pkg::ctrl_cmd_t  cmd_o
);

  krd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= krd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      krd_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.slot_free && status_i.rep_start) begin
          state_d = krd_pkg::ST_EMIT;
        end
      end
      krd_pkg::ST_EMIT: begin
        if (status_i.slot_free && status_i.pend_one) begin
          state_d = krd_pkg::ST_IDLE;
        end
      end
      default: state_d = krd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      krd_pkg::ST_IDLE: begin
        in_ready_o = status_i.slot_free;
        cmd_o.take = in_valid_i && status_i.slot_free;
      end
      krd_pkg::ST_EMIT: begin
        cmd_o.pop = status_i.slot_free;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/krd_datapath.sv @@
// Datapath: config registers, held mask, countdown, pending repeats, output register.
module krd_datapath #(
  parameter int NUM_KEYS = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write
  input  logic                         cfg_we_i,
  input  logic [krd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [krd_pkg::CfgDataW-1:0] cfg_data_i,
  // input payload
  input  logic                         action_i,
  input  logic [krd_pkg::KeyW-1:0]     key_code_i,
  input  logic                         pressed_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [krd_pkg::KeyW-1:0]     out_key_o,
  output logic                         out_pressed_o,
  output logic                         is_repeat_o,
  output logic                         last_o,
  // control
  input  krd_pkg::ctrl_cmd_t           cmd_i,
  output krd_pkg::dp_status_t          status_o
);

  logic [krd_pkg::CntW-1:0]     delay_q, period_q;
  logic [krd_pkg::RepMaskW-1:0] rmask_q;
  logic [NUM_KEYS-1:0]          held_q, held_d;
  logic [NUM_KEYS-1:0]          pend_q, pend_d;
  logic [krd_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic                         ov_q, ov_d;
  logic [krd_pkg::KeyW-1:0]     okey_q, okey_d;
  logic                         opress_q, opress_d, orep_q, orep_d, olast_q, olast_d;

  logic [NUM_KEYS-1:0] rmask_ext, key_hit, held_new, send, pend_low, pend_rest;
  logic [krd_pkg::KeyW-1:0] low_idx;
  logic key_ok, is_tick, expire, slot_free;

  // repeat mask widened to the key count; keys at code 9 (RepMaskW) and above never repeat
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_keys
    if (k < krd_pkg::RepMaskW && k < 16) begin : g_rm
      assign rmask_ext[k] = rmask_q[k];
    end else begin : g_nrm
      assign rmask_ext[k] = 1'b0;
    end
    assign key_hit[k]  = ({1'b0, key_code_i} == 5'(k));
    assign held_new[k] = key_hit[k] ? pressed_i : held_q[k];
  end

  assign key_ok    = int'(key_code_i) < NUM_KEYS;
  assign is_tick   = (action_i == krd_pkg::ActTick);
  assign expire    = run_q && (cnt_q <= krd_pkg::CntW'(1));
  assign send      = held_q & rmask_ext;
  assign slot_free = !ov_q || out_ready_i;

  // lowest pending repeat
  assign pend_low  = pend_q & (~pend_q + NUM_KEYS'(1));
  assign pend_rest = pend_q & ~pend_low;
  always_comb begin
    low_idx = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (pend_low[k]) low_idx = low_idx | krd_pkg::KeyW'(k);
    end
  end

  assign status_o.slot_free = slot_free;
  assign status_o.rep_start = is_tick && expire && (send != '0);
  assign status_o.pend_one  = (pend_rest == '0);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= krd_pkg::DelayRst;
      period_q <= krd_pkg::PeriodRst;
      rmask_q  <= krd_pkg::MaskRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        krd_pkg::CFG_DELAY:  delay_q  <= cfg_data_i;
        krd_pkg::CFG_PERIOD: period_q <= cfg_data_i;
        krd_pkg::CFG_MASK:   rmask_q  <= cfg_data_i[krd_pkg::RepMaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    held_d   = held_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    ov_d     = ov_q && !out_ready_i;
    okey_d   = okey_q;
    opress_d = opress_q;
    orep_d   = orep_q;
    olast_d  = olast_q;
    if (cmd_i.take) begin
      if (!is_tick) begin
        if (key_ok) begin
          held_d   = held_new;
          ov_d     = 1'b1;
          okey_d   = key_code_i;
          opress_d = pressed_i;
          orep_d   = 1'b0;
          olast_d  = 1'b1;
          if ((held_new & rmask_ext) != '0) begin
            cnt_d = delay_q;
            run_d = 1'b1;
          end else begin
            cnt_d = '0;
            run_d = 1'b0;
          end
        end
      end else if (run_q) begin
        if (!expire) begin
          cnt_d = cnt_q - krd_pkg::CntW'(1);
        end else if (send == '0) begin
          cnt_d = '0;
          run_d = 1'b0;
        end else begin
          pend_d = send;
          cnt_d  = period_q;
        end
      end
    end else if (cmd_i.pop) begin
      pend_d   = pend_rest;
      ov_d     = 1'b1;
      okey_d   = low_idx;
      opress_d = 1'b1;
      orep_d   = 1'b1;
      olast_d  = (pend_rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      held_q <= held_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okey_q   <= okey_d;
    opress_q <= opress_d;
    orep_q   <= orep_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign out_key_o     = okey_q;
  assign out_pressed_o = opress_q;
  assign is_repeat_o   = orep_q;
  assign last_o        = olast_q;

endmodule

@@ rtl/key_repeat_dispatcher_top.sv @@
// Top level of the key repeat dispatcher: typematic repeat for a small key pad.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  in_i    | in  | valid / ready     | action, key_code, pressed
//  cfg_i   | in  | valid / ready     | index (0 delay, 1 period, 2 mask), data
//  out_o   | out | valid / ready     | out_key, out_pressed, is_repeat, last
//
// Sequence: a key event or a tick with no result is a single transaction; a tick
//   whose countdown runs out is followed by N repeats (N up to NUM_KEYS),
//   one result per cycle from the controller's emit state unless out_o stalls.
// The single output register sets the rate: outside a repeat burst, a new input
//   transaction is taken when that register is empty or drained in the same cycle.
// Reset: rst_ni is asynchronous; config returns to delay 500, period 30,
//   mask 0x03C; no keys held, countdown stopped. No clearing pass.
// Stalls: out_o.ready low holds the result and blocks further input;
//   cfg_i.ready is always high.
module key_repeat_dispatcher_top #(
  parameter int NUM_KEYS = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  krd_in_if.sink     in_i,
  krd_cfg_if.sink    cfg_i,
  krd_out_if.source  out_o
);

  krd_pkg::ctrl_cmd_t  cmd;
  krd_pkg::dp_status_t status;

  // config writes are always accepted and land in the config registers in the following cycle
  assign cfg_i.ready = 1'b1;

  krd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  krd_datapath #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .action_i      (in_i.action),
    .key_code_i    (in_i.key_code),
    .pressed_i     (in_i.pressed),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_key_o     (out_o.out_key),
    .out_pressed_o (out_o.out_pressed),
    .is_repeat_o   (out_o.is_repeat),
    .last_o        (out_o.last),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

@@ rtl/krd_checker.sv @@
// Port-level checker for the key repeat dispatcher, with its bind.
`include "key_repeat_dispatcher_top_assert.svh"

module krd_checker #(
  parameter int NUM_KEYS = 9
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     action,
  input logic [krd_pkg::KeyW-1:0] key_code,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [krd_pkg::KeyW-1:0] out_key,
  input logic                     out_pressed,
  input logic                     is_repeat,
  input logic                     last
);

  logic in_acc, key_acc;

  assign in_acc  = in_valid && in_ready;
  assign key_acc = in_acc && (action == krd_pkg::ActKey) && (int'(key_code) < NUM_KEYS);

  // a stalled result holds its key
  `KRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key))
  // no input taken while a result is stuck
  `KRD_ASSERT_IMP(a_no_take_on_stall, in_ready && out_valid, out_ready)
  // no input taken in the middle of a repeat burst
  `KRD_ASSERT_IMP(a_burst_blocks, out_valid && !last, !in_ready)
  // a known key event passes through next cycle as a single result
  `KRD_ASSERT_NXT(a_pass_through, key_acc,
                  out_valid && !is_repeat && last && out_key == $past(key_code))
  // repeats are always presses
  `KRD_ASSERT_IMP(a_repeat_press, out_valid && is_repeat, out_pressed)

endmodule

bind key_repeat_dispatcher_top krd_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_krd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .action      (in_i.action),
  .key_code    (in_i.key_code),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_key     (out_o.out_key),
  .out_pressed (out_o.out_pressed),
  .is_repeat   (out_o.is_repeat),
  .last        (out_o.last)
);
